### src/blas1vr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blas1vr_pkg
// Shared widths, mode codes, register indexes and controller/datapath links
// for the level-1 vector reduction unit.
// ----------------------------------------------------------------------------
package blas1vr_pkg;

  localparam int IN_W            = 16;   // component width at the ports
  localparam int ACC_W           = 48;   // accumulator and result width
  localparam int IDX_W           = 16;   // best index width at the port
  localparam int ROOT_W          = ACC_W / 2;
  localparam int MODE_W          = 3;
  localparam int CFG_IDX_W       = 1;
  localparam int MAX_LENGTH_DEF  = 65536;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // reduction modes
  localparam logic [MODE_W-1:0] MODE_DOT    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DOTU   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DOTC   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_NORM   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ASUM   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_ARGMAX = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CPLX = 1'd1;

  typedef struct packed {
    logic accept;      // input request taken this cycle
    logic adv;         // pipeline stages move
    logic acc_en;      // accumulate stage holds a request and moves
    logic retire;      // last element of a vector leaves the accumulators
    logic root_start;  // hand the sum of squares to the root unit
    logic out_load;    // load output register from the accumulators
    logic root_load;   // load output register from the root unit
  } cmd_t;

  typedef struct packed {
    logic s2_norm;     // request at the accumulate stage is in norm mode
    logic root_done;   // root unit finished
  } sts_t;

endpackage

### src/blas1vr_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blas1vr_sqrt
// Iterative floor square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module blas1vr_sqrt (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [blas1vr_pkg::ACC_W-1:0]    radicand,
  output logic [blas1vr_pkg::ROOT_W-1:0]   root,
  output logic                             done
);

  localparam int RW = blas1vr_pkg::ROOT_W + 2;
  localparam int AW = blas1vr_pkg::ACC_W;
  localparam int SW = $clog2(blas1vr_pkg::ROOT_W);

  logic [AW-1:0]                   rad_r;
  logic [RW-1:0]                   rem_r;
  logic [blas1vr_pkg::ROOT_W-1:0]  root_r;
  logic [SW-1:0]                   step_r;
  logic                            busy_r;
  logic                            done_r;

  logic [RW-1:0]                   rem_sh;
  logic [RW-1:0]                   trial;
  logic                            take;
  logic [RW-1:0]                   rem_nxt;
  logic [blas1vr_pkg::ROOT_W-1:0]  root_nxt;

  always_comb begin
    rem_sh   = {rem_r[RW-3:0], rad_r[AW-1:AW-2]};
    trial    = {root_r, 2'b01};
    take     = (rem_sh >= trial);
    rem_nxt  = take ? (rem_sh - trial) : rem_sh;
    root_nxt = {root_r[blas1vr_pkg::ROOT_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= SW'(blas1vr_pkg::ROOT_W - 1);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[AW-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign root = root_r;
  assign done = done_r;

endmodule

### src/blas1vr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blas1vr_ctrl
// Controller: stage valids, vector end handling, root wait and output flag.
// ----------------------------------------------------------------------------
module blas1vr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_last_element,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  blas1vr_pkg::sts_t   sts,
  output blas1vr_pkg::cmd_t   cmd
);

  typedef enum logic [0:0] {
    ST_RUN,
    ST_ROOT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   s1_valid_r;
  logic   s1_last_r;
  logic   s2_valid_r;
  logic   s2_last_r;
  logic   can_finish;
  logic   hold;

  always_comb begin
    // a vector end may leave only when the root unit is free and the output
    // register is empty or being emptied
    can_finish     = (state_r == ST_RUN) && (!out_valid_r || !out_stall);
    hold           = s2_valid_r && s2_last_r && !can_finish;
    cmd.adv        = !hold;
    cmd.accept     = in_valid && !hold;
    cmd.acc_en     = s2_valid_r && !hold;
    cmd.retire     = s2_valid_r && s2_last_r && !hold;
    cmd.root_start = cmd.retire && sts.s2_norm;
    cmd.out_load   = cmd.retire && !sts.s2_norm;
    cmd.root_load  = (state_r == ST_ROOT) && sts.root_done;

    state_nxt = state_r;
    case (state_r)
      ST_RUN: begin
        if (cmd.root_start) state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        if (sts.root_done) state_nxt = ST_RUN;
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      out_valid_r <= 1'b0;
      s1_valid_r  <= 1'b0;
      s1_last_r   <= 1'b0;
      s2_valid_r  <= 1'b0;
      s2_last_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.adv) begin
        s1_valid_r <= in_valid;
        s1_last_r  <= in_last_element;
        s2_valid_r <= s1_valid_r;
        s2_last_r  <= s1_last_r;
      end
      if (cmd.out_load || cmd.root_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_stall  = hold;
  assign out_valid = out_valid_r;

endmodule

### src/blas1vr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blas1vr_datapath
// Product stage, term stage, saturating accumulators, argmax tracking,
// element counter, root unit and output register.
// ----------------------------------------------------------------------------
module blas1vr_datapath #(
  parameter int MAX_LENGTH  = blas1vr_pkg::MAX_LENGTH_DEF,
  parameter int SAMPLE_BITS = blas1vr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  blas1vr_pkg::cmd_t                        cmd,
  output blas1vr_pkg::sts_t                        sts,
  input  logic                                     cfg_we,
  input  logic [blas1vr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [blas1vr_pkg::MODE_W-1:0]           cfg_data,
  input  logic signed [blas1vr_pkg::IN_W-1:0]      in_x_real,
  input  logic signed [blas1vr_pkg::IN_W-1:0]      in_x_imag,
  input  logic signed [blas1vr_pkg::IN_W-1:0]      in_y_real,
  input  logic signed [blas1vr_pkg::IN_W-1:0]      in_y_imag,
  input  logic                                     in_last_element,
  output logic signed [blas1vr_pkg::ACC_W-1:0]     out_result_real,
  output logic signed [blas1vr_pkg::ACC_W-1:0]     out_result_imag,
  output logic [blas1vr_pkg::IDX_W-1:0]            out_best_index,
  output logic                                     out_saturated
);

  localparam int SB    = SAMPLE_BITS;
  localparam int IN_W  = blas1vr_pkg::IN_W;
  localparam int EXT_W = (SB > IN_W) ? SB : IN_W;
  localparam int PW    = 2 * SB;
  localparam int TW    = PW + 1;
  localparam int MAG_W = SB + 1;
  localparam int CW    = $clog2(MAX_LENGTH);
  localparam int ACC_W = blas1vr_pkg::ACC_W;
  localparam int SUM_W = ((TW > ACC_W) ? TW : ACC_W) + 1;
  localparam int MW    = blas1vr_pkg::MODE_W;

  // configuration
  logic [MW-1:0] mode_r;
  logic          cplx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= blas1vr_pkg::MODE_DOT;
      cplx_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        blas1vr_pkg::CFG_MODE: mode_r <= cfg_data;
        blas1vr_pkg::CFG_CPLX: cplx_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // samples from the low bits of each component
  logic [EXT_W-1:0]     xr_ext, xi_ext, yr_ext, yi_ext;
  logic signed [SB-1:0] s_xr, s_xi, s_yr, s_yi;
  logic signed [SB-1:0] opb1, opb2;
  logic [SB-1:0]        abs_xr, abs_xi;
  logic [MAG_W-1:0]     mag_nxt;
  logic                 in_norm;

  always_comb begin
    xr_ext  = EXT_W'($unsigned(in_x_real));
    xi_ext  = EXT_W'($unsigned(in_x_imag));
    yr_ext  = EXT_W'($unsigned(in_y_real));
    yi_ext  = EXT_W'($unsigned(in_y_imag));
    s_xr    = signed'(xr_ext[SB-1:0]);
    s_xi    = signed'(xi_ext[SB-1:0]);
    s_yr    = signed'(yr_ext[SB-1:0]);
    s_yi    = signed'(yi_ext[SB-1:0]);
    in_norm = (mode_r == blas1vr_pkg::MODE_NORM);
    // norm squares x, so the first two multipliers take x on both sides
    opb1    = in_norm ? s_xr : s_yr;
    opb2    = in_norm ? s_xi : s_yi;
    abs_xr  = s_xr[SB-1] ? $unsigned(-s_xr) : $unsigned(s_xr);
    abs_xi  = s_xi[SB-1] ? $unsigned(-s_xi) : $unsigned(s_xi);
    mag_nxt = MAG_W'(abs_xr) + (cplx_r ? MAG_W'(abs_xi) : MAG_W'(0));
  end

  // element counter
  logic [CW-1:0] count_r;
  logic          count_full;

  assign count_full = (count_r == CW'(MAX_LENGTH - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.accept) begin
      if (in_last_element) begin
        count_r <= '0;
      end else if (!count_full) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  // product stage
  logic signed [PW-1:0] s1_pa_r, s1_pb_r, s1_pc_r, s1_pd_r;
  logic [MAG_W-1:0]     s1_mag_r;
  logic [MW-1:0]        s1_mode_r;
  logic                 s1_cplx_r;
  logic [CW-1:0]        s1_pos_r;
  logic                 s1_ovf_r;

  always_ff @(posedge clk) begin
    if (cmd.adv) begin
      s1_pa_r   <= PW'(s_xr) * PW'(opb1);
      s1_pb_r   <= PW'(s_xi) * PW'(opb2);
      s1_pc_r   <= PW'(s_xr) * PW'(s_yi);
      s1_pd_r   <= PW'(s_xi) * PW'(s_yr);
      s1_mag_r  <= mag_nxt;
      s1_mode_r <= mode_r;
      s1_cplx_r <= cplx_r;
      s1_pos_r  <= count_r;
      s1_ovf_r  <= !in_last_element && count_full;
    end
  end

  // term stage
  logic signed [TW-1:0] term_re_nxt, term_im_nxt;

  always_comb begin
    term_re_nxt = '0;
    term_im_nxt = '0;
    case (s1_mode_r)
      blas1vr_pkg::MODE_DOT: begin
        term_re_nxt = TW'(s1_pa_r);
      end
      blas1vr_pkg::MODE_DOTU: begin
        term_re_nxt = TW'(s1_pa_r) - TW'(s1_pb_r);
        term_im_nxt = TW'(s1_pc_r) + TW'(s1_pd_r);
      end
      blas1vr_pkg::MODE_DOTC: begin
        term_re_nxt = TW'(s1_pa_r) + TW'(s1_pb_r);
        term_im_nxt = TW'(s1_pc_r) - TW'(s1_pd_r);
      end
      blas1vr_pkg::MODE_NORM: begin
        term_re_nxt = TW'(s1_pa_r) + (s1_cplx_r ? TW'(s1_pb_r) : TW'(0));
      end
      blas1vr_pkg::MODE_ASUM: begin
        term_re_nxt = signed'(TW'(s1_mag_r));
      end
      default: ;
    endcase
  end

  logic signed [TW-1:0] s2_term_re_r, s2_term_im_r;
  logic [MAG_W-1:0]     s2_mag_r;
  logic [MW-1:0]        s2_mode_r;
  logic [CW-1:0]        s2_pos_r;
  logic                 s2_ovf_r;

  always_ff @(posedge clk) begin
    if (cmd.adv) begin
      s2_term_re_r <= term_re_nxt;
      s2_term_im_r <= term_im_nxt;
      s2_mag_r     <= s1_mag_r;
      s2_mode_r    <= s1_mode_r;
      s2_pos_r     <= s1_pos_r;
      s2_ovf_r     <= s1_ovf_r;
    end
  end

  // accumulate stage
  logic signed [ACC_W-1:0] acc_re_r, acc_im_r;
  logic [CW-1:0]           best_pos_r;
  logic [MAG_W-1:0]        best_mag_r;
  logic                    clip_r;

  logic signed [SUM_W-1:0] sum_re, sum_im;
  logic signed [ACC_W-1:0] acc_re_nxt, acc_im_nxt;
  logic                    clip_re, clip_im;
  logic                    upd_re, upd_im, upd_best;
  logic [CW-1:0]           best_pos_nxt;
  logic [MAG_W-1:0]        best_mag_nxt;
  logic                    clip_nxt;
  logic [ACC_W-1:0]        radicand;

  always_comb begin
    upd_re = s2_mode_r inside {blas1vr_pkg::MODE_DOT, blas1vr_pkg::MODE_DOTU,
                               blas1vr_pkg::MODE_DOTC, blas1vr_pkg::MODE_NORM,
                               blas1vr_pkg::MODE_ASUM};
    upd_im = s2_mode_r inside {blas1vr_pkg::MODE_DOTU, blas1vr_pkg::MODE_DOTC};

    sum_re = SUM_W'(acc_re_r) + SUM_W'(s2_term_re_r);
    sum_im = SUM_W'(acc_im_r) + SUM_W'(s2_term_im_r);

    acc_re_nxt = acc_re_r;
    clip_re    = 1'b0;
    if (upd_re) begin
      if (sum_re > SUM_W'(blas1vr_pkg::ACC_MAX)) begin
        acc_re_nxt = blas1vr_pkg::ACC_MAX;
        clip_re    = 1'b1;
      end else if (sum_re < SUM_W'(blas1vr_pkg::ACC_MIN)) begin
        acc_re_nxt = blas1vr_pkg::ACC_MIN;
        clip_re    = 1'b1;
      end else begin
        acc_re_nxt = sum_re[ACC_W-1:0];
      end
    end

    acc_im_nxt = acc_im_r;
    clip_im    = 1'b0;
    if (upd_im) begin
      if (sum_im > SUM_W'(blas1vr_pkg::ACC_MAX)) begin
        acc_im_nxt = blas1vr_pkg::ACC_MAX;
        clip_im    = 1'b1;
      end else if (sum_im < SUM_W'(blas1vr_pkg::ACC_MIN)) begin
        acc_im_nxt = blas1vr_pkg::ACC_MIN;
        clip_im    = 1'b1;
      end else begin
        acc_im_nxt = sum_im[ACC_W-1:0];
      end
    end

    // strictly larger wins, so ties keep the first index
    upd_best     = (s2_mode_r == blas1vr_pkg::MODE_ARGMAX) && (s2_mag_r > best_mag_r);
    best_pos_nxt = upd_best ? s2_pos_r : best_pos_r;
    best_mag_nxt = upd_best ? s2_mag_r : best_mag_r;
    clip_nxt     = clip_r || s2_ovf_r || clip_re || clip_im;

    radicand = acc_re_nxt[ACC_W-1] ? '0 : $unsigned(acc_re_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_re_r   <= '0;
      acc_im_r   <= '0;
      best_pos_r <= '0;
      best_mag_r <= '0;
      clip_r     <= 1'b0;
    end else if (cmd.acc_en) begin
      if (cmd.retire) begin
        acc_re_r   <= '0;
        acc_im_r   <= '0;
        best_pos_r <= '0;
        best_mag_r <= '0;
        clip_r     <= 1'b0;
      end else begin
        acc_re_r   <= acc_re_nxt;
        acc_im_r   <= acc_im_nxt;
        best_pos_r <= best_pos_nxt;
        best_mag_r <= best_mag_nxt;
        clip_r     <= clip_nxt;
      end
    end
  end

  // root unit
  logic [blas1vr_pkg::ROOT_W-1:0] root;
  logic                           root_done;
  logic                           root_clip_r;

  blas1vr_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.root_start),
    .radicand (radicand),
    .root     (root),
    .done     (root_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.root_start) root_clip_r <= clip_nxt;
  end

  assign sts.root_done = root_done;
  assign sts.s2_norm   = (s2_mode_r == blas1vr_pkg::MODE_NORM);

  // output register
  logic signed [ACC_W-1:0]       res_re_nxt, res_im_nxt;
  logic [blas1vr_pkg::IDX_W-1:0] res_idx_nxt;

  always_comb begin
    res_re_nxt  = '0;
    res_im_nxt  = '0;
    res_idx_nxt = '0;
    case (s2_mode_r)
      blas1vr_pkg::MODE_DOT,
      blas1vr_pkg::MODE_ASUM: begin
        res_re_nxt = acc_re_nxt;
      end
      blas1vr_pkg::MODE_DOTU,
      blas1vr_pkg::MODE_DOTC: begin
        res_re_nxt = acc_re_nxt;
        res_im_nxt = acc_im_nxt;
      end
      blas1vr_pkg::MODE_ARGMAX: begin
        res_idx_nxt = blas1vr_pkg::IDX_W'(best_pos_nxt);
      end
      default: ;
    endcase
  end

  logic signed [ACC_W-1:0]       res_re_r, res_im_r;
  logic [blas1vr_pkg::IDX_W-1:0] res_idx_r;
  logic                          res_sat_r;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_re_r  <= res_re_nxt;
      res_im_r  <= res_im_nxt;
      res_idx_r <= res_idx_nxt;
      res_sat_r <= clip_nxt;
    end else if (cmd.root_load) begin
      res_re_r  <= signed'(ACC_W'(root));
      res_im_r  <= '0;
      res_idx_r <= '0;
      res_sat_r <= root_clip_r;
    end
  end

  assign out_result_real = res_re_r;
  assign out_result_imag = res_im_r;
  assign out_best_index  = res_idx_r;
  assign out_saturated   = res_sat_r;

endmodule

### src/blas1_vector_reduction_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blas1_vector_reduction_unit
// Streaming fixed-point dot, dotu, dotc, norm, absolute sum and argmax.
// ----------------------------------------------------------------------------
// One vector element is taken per clock unless in_stall is high; the vector
// ends on the request that carries last_element, and one result follows it.
// Products are formed in a first stage, combined into terms in a second and
// summed into 48-bit saturating accumulators in a third; a dot, absolute sum
// or argmax result is loaded into the output register as its last element
// leaves the accumulate stage. The norm passes the sum of squares to a
// shift-subtract root unit that settles two radicand bits per cycle. Elements
// of the next vector keep streaming while the root runs; only its last
// element waits until the root unit has finished and the output register is
// free. The output register holds a result while it is stalled, with the
// pipeline behind it still taking elements.
module blas1_vector_reduction_unit #(
  parameter int MAX_LENGTH  = blas1vr_pkg::MAX_LENGTH_DEF,
  parameter int SAMPLE_BITS = blas1vr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_we,
  input  logic [blas1vr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [blas1vr_pkg::MODE_W-1:0]           cfg_data,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic signed [blas1vr_pkg::IN_W-1:0]      in_x_real,
  input  logic signed [blas1vr_pkg::IN_W-1:0]      in_x_imag,
  input  logic signed [blas1vr_pkg::IN_W-1:0]      in_y_real,
  input  logic signed [blas1vr_pkg::IN_W-1:0]      in_y_imag,
  input  logic                                     in_last_element,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic signed [blas1vr_pkg::ACC_W-1:0]     out_result_real,
  output logic signed [blas1vr_pkg::ACC_W-1:0]     out_result_imag,
  output logic [blas1vr_pkg::IDX_W-1:0]            out_best_index,
  output logic                                     out_saturated
);

  blas1vr_pkg::cmd_t cmd;
  blas1vr_pkg::sts_t sts;

  blas1vr_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_last_element (in_last_element),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .sts             (sts),
    .cmd             (cmd)
  );

  blas1vr_datapath #(
    .MAX_LENGTH  (MAX_LENGTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_x_real       (in_x_real),
    .in_x_imag       (in_x_imag),
    .in_y_real       (in_y_real),
    .in_y_imag       (in_y_imag),
    .in_last_element (in_last_element),
    .out_result_real (out_result_real),
    .out_result_imag (out_result_imag),
    .out_best_index  (out_best_index),
    .out_saturated   (out_saturated)
  );

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the level-1 vector reduction unit. Vectors of
// elements are streamed under every reduction mode and data format; each
// accepted request updates a local model of the accumulators, and every
// vector result is checked field by field against the model's prediction.
// ----------------------------------------------------------------------------
module tb;

  localparam int IN_W      = blas1vr_pkg::IN_W;
  localparam int ACC_W     = blas1vr_pkg::ACC_W;
  localparam int IDX_W     = blas1vr_pkg::IDX_W;
  localparam int MODE_W    = blas1vr_pkg::MODE_W;
  localparam int CFG_IDX_W = blas1vr_pkg::CFG_IDX_W;

  localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;
  localparam logic [MODE_W-1:0] REAL_DATA    = 3'd0;
  localparam logic [MODE_W-1:0] COMPLEX_DATA = 3'd1;
  localparam int LAST_POS      = blas1vr_pkg::MAX_LENGTH_DEF - 1;
  localparam int SETTLE_CYCLES = 40;   // covers the norm path through the root unit
  localparam int RANDOM_ITEMS  = 850;

  typedef struct packed {
    logic signed [ACC_W-1:0] re;
    logic signed [ACC_W-1:0] im;
    logic [IDX_W-1:0]        idx;
    logic                    sat;
  } reduction_t;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [MODE_W-1:0]       cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [IN_W-1:0]  in_x_real;
  logic signed [IN_W-1:0]  in_x_imag;
  logic signed [IN_W-1:0]  in_y_real;
  logic signed [IN_W-1:0]  in_y_imag;
  logic                    in_last_element;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [ACC_W-1:0] out_result_real;
  logic signed [ACC_W-1:0] out_result_imag;
  logic [IDX_W-1:0]        out_best_index;
  logic                    out_saturated;

  // local model of the unit
  logic [MODE_W-1:0] cur_mode = blas1vr_pkg::MODE_DOT;
  logic              cur_cplx = 1'b0;
  longint            acc_re = 0;
  longint            acc_im = 0;
  int                elem_pos = 0;
  int                lead_pos = 0;
  longint            lead_mag = 0;
  logic              vec_clipped = 1'b0;

  reduction_t pending_results[$];
  reduction_t head_result;
  int         mismatch_count = 0;
  bit         gaps_on = 1'b1;

  blas1_vector_reduction_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_x_real       (in_x_real),
    .in_x_imag       (in_x_imag),
    .in_y_real       (in_y_real),
    .in_y_imag       (in_y_imag),
    .in_last_element (in_last_element),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_real (out_result_real),
    .out_result_imag (out_result_imag),
    .out_best_index  (out_best_index),
    .out_saturated   (out_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #15ms;
    $display("Verification failed");
    $finish;
  end

  function automatic longint clamp_add(input longint acc, input longint term);
    longint s;
    s = acc + term;
    if (s > longint'(blas1vr_pkg::ACC_MAX)) begin
      vec_clipped = 1'b1;
      return longint'(blas1vr_pkg::ACC_MAX);
    end
    if (s < longint'(blas1vr_pkg::ACC_MIN)) begin
      vec_clipped = 1'b1;
      return longint'(blas1vr_pkg::ACC_MIN);
    end
    return s;
  endfunction

  function automatic longint magnitude_of(input longint a, input longint b);
    longint m;
    m = (a < 0) ? -a : a;
    if (cur_cplx)
      m += (b < 0) ? -b : b;
    return m;
  endfunction

  // largest r with r*r <= v, built one bit at a time from the top
  function automatic longint floor_root(input longint v);
    longint r;
    longint t;
    r = 0;
    for (int b = 23; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= v)
        r = t;
    end
    return r;
  endfunction

  function automatic logic signed [IN_W-1:0] pick_sample(input bit narrow);
    int r;
    if (narrow)
      return IN_W'($urandom_range(0, 8) - 4);
    r = int'($urandom_range(99));
    if (r < 8)
      return {1'b1, {(IN_W-1){1'b0}}};
    if (r < 16)
      return {1'b0, {(IN_W-1){1'b1}}};
    if (r < 20)
      return '0;
    if (r < 24)
      return '1;
    return IN_W'($urandom);
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s at %0t: got %0d expected %0d", what, $time, got, want);
    mismatch_count++;
  endtask

  task automatic absorb_element(input logic signed [IN_W-1:0] xr, xi, yr, yi,
                                input logic lst);
    longint a, b, c, d, mag;
    reduction_t res;
    a = longint'(xr);
    b = longint'(xi);
    c = longint'(yr);
    d = longint'(yi);
    case (cur_mode)
      blas1vr_pkg::MODE_DOT: acc_re = clamp_add(acc_re, a * c);
      blas1vr_pkg::MODE_DOTU: begin
        acc_re = clamp_add(acc_re, a * c - b * d);
        acc_im = clamp_add(acc_im, a * d + b * c);
      end
      blas1vr_pkg::MODE_DOTC: begin
        acc_re = clamp_add(acc_re, a * c + b * d);
        acc_im = clamp_add(acc_im, a * d - b * c);
      end
      blas1vr_pkg::MODE_NORM: acc_re = clamp_add(acc_re, a * a + (cur_cplx ? b * b : 0));
      blas1vr_pkg::MODE_ASUM: acc_re = clamp_add(acc_re, magnitude_of(a, b));
      blas1vr_pkg::MODE_ARGMAX: begin
        mag = magnitude_of(a, b);
        if (mag > lead_mag) begin
          lead_mag = mag;
          lead_pos = elem_pos;
        end
      end
      default: ;
    endcase

    if (!lst) begin
      // the index sticks at the top and the vector is marked clipped
      if (elem_pos >= LAST_POS)
        vec_clipped = 1'b1;
      else
        elem_pos++;
    end else begin
      res = '0;
      case (cur_mode)
        blas1vr_pkg::MODE_DOT, blas1vr_pkg::MODE_ASUM: res.re = ACC_W'(acc_re);
        blas1vr_pkg::MODE_DOTU, blas1vr_pkg::MODE_DOTC: begin
          res.re = ACC_W'(acc_re);
          res.im = ACC_W'(acc_im);
        end
        blas1vr_pkg::MODE_NORM:   res.re = ACC_W'(floor_root((acc_re < 0) ? 0 : acc_re));
        blas1vr_pkg::MODE_ARGMAX: res.idx = IDX_W'(lead_pos);
        default: ;
      endcase
      res.sat = vec_clipped;
      pending_results.push_back(res);
      acc_re = 0;
      acc_im = 0;
      elem_pos = 0;
      lead_pos = 0;
      lead_mag = 0;
      vec_clipped = 1'b0;
    end
  endtask

  task automatic send_element(input logic signed [IN_W-1:0] xr, xi, yr, yi,
                              input logic lst);
    int idle_cycles;
    int r;
    idle_cycles = 0;
    if (gaps_on) begin
      r = int'($urandom_range(99));
      if (r >= 97)
        idle_cycles = int'($urandom_range(15, 40));
      else if (r >= 88)
        idle_cycles = int'($urandom_range(4, 10));
      else if (r >= 55)
        idle_cycles = int'($urandom_range(1, 3));
    end
    if (idle_cycles > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (idle_cycles - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_x_real       <= xr;
    in_x_imag       <= xi;
    in_y_real       <= yr;
    in_y_imag       <= yi;
    in_last_element <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_element(xr, xi, yr, yi, lst);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MODE_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == blas1vr_pkg::CFG_MODE)
      cur_mode = val;
    else
      cur_cplx = val[0];
  endtask

  task automatic drain_pipeline();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result side: random stalls with calm stretches in between
  initial begin
    int stall_left;
    int calm_left;
    int r;
    stall_left = 0;
    calm_left = 0;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (calm_left > 0) begin
          calm_left--;
        end else begin
          r = int'($urandom_range(99));
          if (r < 3)
            calm_left = int'($urandom_range(50, 300));
          else if (r < 22)
            stall_left = int'($urandom_range(1, 3));
          else if (r < 25)
            stall_left = int'($urandom_range(8, 30));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result with no request pending", longint'(out_result_real), 0);
      end else begin
        head_result = pending_results.pop_front();
        if (out_result_real !== head_result.re)
          flag_mismatch("result_real", longint'(out_result_real),
                        longint'(head_result.re));
        if (out_result_imag !== head_result.im)
          flag_mismatch("result_imag", longint'(out_result_imag),
                        longint'(head_result.im));
        if (out_best_index !== head_result.idx)
          flag_mismatch("best_index", longint'(out_best_index),
                        longint'(head_result.idx));
        if (out_saturated !== head_result.sat)
          flag_mismatch("saturated", longint'(out_saturated),
                        longint'(head_result.sat));
      end
    end
  end

  task automatic test_dot_modes();
    // real dot ignores the complex flag and the imaginary parts
    write_reg(blas1vr_pkg::CFG_MODE, blas1vr_pkg::MODE_DOT);
    write_reg(blas1vr_pkg::CFG_CPLX, COMPLEX_DATA);
    send_element(-16'sd32768, 16'sd123, -16'sd32768, -16'sd77, 1'b0);
    send_element(16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, 1'b1);
    drain_pipeline();
    // complex dots use both parts even for real data
    write_reg(blas1vr_pkg::CFG_MODE, blas1vr_pkg::MODE_DOTU);
    write_reg(blas1vr_pkg::CFG_CPLX, REAL_DATA);
    send_element(-16'sd32768, -16'sd32768, -16'sd32768, 16'sd32767, 1'b0);
    send_element(16'sd32767, -16'sd32768, -16'sd1, -16'sd32768, 1'b1);
    drain_pipeline();
    write_reg(blas1vr_pkg::CFG_MODE, blas1vr_pkg::MODE_DOTC);
    send_element(-16'sd32768, 16'sd32767, -16'sd32768, -16'sd32768, 1'b1);
    drain_pipeline();
  endtask

  task automatic test_norm_and_abs_sum();
    write_reg(blas1vr_pkg::CFG_MODE, blas1vr_pkg::MODE_NORM);
    send_element(-16'sd32768, -16'sd32768, 16'sd0, 16'sd0, 1'b0);
    send_element(16'sd32767, 16'sd5, 16'sd0, 16'sd0, 1'b1);
    drain_pipeline();
    write_reg(blas1vr_pkg::CFG_CPLX, COMPLEX_DATA);
    send_element(-16'sd32768, -16'sd32768, 16'sd9, -16'sd9, 1'b1);
    drain_pipeline();
    write_reg(blas1vr_pkg::CFG_MODE, blas1vr_pkg::MODE_ASUM);
    send_element(-16'sd32768, -16'sd32768, 16'sd0, 16'sd0, 1'b0);
    send_element(16'sd1, -16'sd1, 16'sd0, 16'sd0, 1'b1);
    drain_pipeline();
    write_reg(blas1vr_pkg::CFG_CPLX, REAL_DATA);
    send_element(-16'sd5, -16'sd32768, 16'sd0, 16'sd0, 1'b1);
    drain_pipeline();
  endtask

  task automatic test_argmax_ties();
    // equal magnitudes keep the earliest index
    write_reg(blas1vr_pkg::CFG_MODE, blas1vr_pkg::MODE_ARGMAX);
    send_element(16'sd5, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    send_element(-16'sd5, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    send_element(-16'sd7, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    send_element(16'sd7, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    send_element(16'sd6, 16'sd0, 16'sd0, 16'sd0, 1'b1);
    drain_pipeline();
    write_reg(blas1vr_pkg::CFG_CPLX, COMPLEX_DATA);
    send_element(16'sd32767, 16'sd32767, 16'sd0, 16'sd0, 1'b0);
    send_element(-16'sd32768, -16'sd32768, 16'sd0, 16'sd0, 1'b0);
    send_element(-16'sd32768, -16'sd32768, 16'sd0, 16'sd0, 1'b1);
    drain_pipeline();
  endtask

  task automatic test_unused_modes();
    write_reg(blas1vr_pkg::CFG_MODE, MODE_SPARE6);
    send_element(16'sd1234, -16'sd32768, 16'sd32767, 16'sd99, 1'b1);
    drain_pipeline();
    write_reg(blas1vr_pkg::CFG_MODE, MODE_SPARE7);
    send_element(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, 1'b0);
    send_element(16'sd77, 16'sd0, -16'sd1, 16'sd1, 1'b1);
    drain_pipeline();
  endtask

  task automatic test_mode_switch_mid_vector();
    // elements taken under real dot, the rest and the result under norm
    write_reg(blas1vr_pkg::CFG_MODE, blas1vr_pkg::MODE_DOT);
    send_element(16'sd1000, 16'sd0, 16'sd2000, 16'sd0, 1'b0);
    send_element(-16'sd300, 16'sd7, 16'sd400, 16'sd9, 1'b0);
    drain_pipeline();
    write_reg(blas1vr_pkg::CFG_MODE, blas1vr_pkg::MODE_NORM);
    send_element(16'sd3, 16'sd4, 16'sd0, 16'sd0, 1'b1);
    drain_pipeline();
  endtask

  task automatic test_random_streams();
    int sent;
    int vectors;
    int len;
    int r;
    bit narrow;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      r = int'($urandom_range(99));
      write_reg(blas1vr_pkg::CFG_MODE, (r < 8) ? MODE_W'($urandom_range(6, 7))
                                               : MODE_W'($urandom_range(0, 5)));
      write_reg(blas1vr_pkg::CFG_CPLX, MODE_W'($urandom_range(0, 7)));
      gaps_on = ($urandom_range(3) != 0);
      vectors = int'($urandom_range(3, 10));
      repeat (vectors) begin
        r = int'($urandom_range(99));
        if (r < 60)
          len = int'($urandom_range(1, 5));
        else if (r < 90)
          len = int'($urandom_range(6, 16));
        else
          len = int'($urandom_range(17, 48));
        narrow = ($urandom_range(3) == 0);
        for (int k = 0; k < len; k++)
          send_element(pick_sample(narrow), pick_sample(narrow), pick_sample(narrow),
                       pick_sample(narrow), k == len - 1);
        sent += len;
      end
      drain_pipeline();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = blas1vr_pkg::CFG_MODE;
    cfg_data        = '0;
    in_valid        = 1'b0;
    in_x_real       = '0;
    in_x_imag       = '0;
    in_y_real       = '0;
    in_y_imag       = '0;
    in_last_element = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    test_dot_modes();
    test_norm_and_abs_sum();
    test_argmax_ties();
    test_unused_modes();
    test_mode_switch_mid_vector();
    test_random_streams();

    if (mismatch_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
